@@ hw/rtl/udc7s_pkg.sv @@
// Shared widths, register indexes, reset values and the segment decode for
// the four-digit up/down counter with seven-segment display.
// No dependencies.
`default_nettype none

package udc7s_pkg;

   // Field and register widths
   localparam int CountWidth    = 14;
   localparam int BeepWidth     = 16;
   localparam int SegWidth      = 7;
   localparam int NumDigits     = 4;
   localparam int ScanWidth     = 2;
   localparam int NumButtons    = 4;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;

   // Count limits and register reset values
   localparam logic [CountWidth-1:0] CountCeiling   = 14'd9999;
   localparam logic [CountWidth-1:0] MaxValueReset  = 14'd9999;
   localparam logic [BeepWidth-1:0]  BeepTicksReset = 16'd10000;

   // Configuration register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MAX_VALUE  = 2'd0,
      CSR_BEEP_TICKS = 2'd1
   } csr_index_type;

   // Button positions in the level vector
   localparam int BtnUp    = 0;
   localparam int BtnDown  = 1;
   localparam int BtnPause = 2;
   localparam int BtnClear = 3;

   // Four decimal digits, ones in element 0
   typedef logic [NumDigits-1:0][3:0] bcd_type;

   // Decode one decimal digit to segments a..g in bits 0..6
   function automatic logic [SegWidth-1:0] seg_of(input logic [3:0] digit);
      logic [SegWidth-1:0] seg;
      case (digit)
         4'd0:    seg = 7'h3F;
         4'd1:    seg = 7'h06;
         4'd2:    seg = 7'h5B;
         4'd3:    seg = 7'h4F;
         4'd4:    seg = 7'h66;
         4'd5:    seg = 7'h6D;
         4'd6:    seg = 7'h7D;
         4'd7:    seg = 7'h07;
         4'd8:    seg = 7'h7F;
         4'd9:    seg = 7'h6F;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/udc7s_req_if.sv @@
// Scan tick channel: valid/ready handshake carrying the four button levels.
// No dependencies.
`default_nettype none

interface udc7s_req_if;
   logic valid;
   logic ready;
   logic up_pressed;
   logic down_pressed;
   logic pause_pressed;
   logic clear_pressed;

   modport source (output valid, output up_pressed, output down_pressed,
                   output pause_pressed, output clear_pressed, input ready);
   modport sink   (input valid, input up_pressed, input down_pressed,
                   input pause_pressed, input clear_pressed, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/udc7s_rsp_if.sv @@
// Result channel: valid/ready handshake carrying one display and LED update.
// Depends on udc7s_pkg for field widths.
`default_nettype none

interface udc7s_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [udc7s_pkg::SegWidth-1:0]       segments;
   logic [udc7s_pkg::NumDigits-1:0]      digit_select_n;
   logic                                 run_led;
   logic                                 red_led;
   logic                                 buzzer;
   logic [udc7s_pkg::CountWidth-1:0]     count_value;

   modport source (output valid, output segments, output digit_select_n,
                   output run_led, output red_led, output buzzer,
                   output count_value, input ready);
   modport sink   (input valid, input segments, input digit_select_n,
                   input run_led, input red_led, input buzzer,
                   input count_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/udc7s_csr_if.sv @@
// Configuration write channel: valid/ready handshake with register index
// and write data. Depends on udc7s_pkg for widths.
`default_nettype none

interface udc7s_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [udc7s_pkg::CsrIndexWidth-1:0]   reg_index;
   logic [udc7s_pkg::CsrDataWidth-1:0]    wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/up_down_counter_seven_segment.sv @@
// Four-digit up/down counter with multiplexed seven-segment display.
// Depends on udc7s_pkg and the udc7s_req_if, udc7s_rsp_if, udc7s_csr_if interfaces.
//
// One scan tick is taken per clock cycle. Button edges, the count, the
// enable flag and the buzzer countdown are all updated at the transfer of a
// tick, and the matching result sits in the output register from the next
// cycle on. The tick channel stalls only while that register holds a result
// the sink has not taken in the same cycle, so the rate is one tick per
// cycle while the sink takes results. The count is kept both in binary and as
// four decimal digits, so the scanned digit is a plain select. Configuration
// writes are always ready and take effect for the next tick.
`default_nettype none

module up_down_counter_seven_segment (
   input  wire               clock,
   input  wire               reset,
   udc7s_req_if.sink         req_ch,
   udc7s_rsp_if.source       rsp_ch,
   udc7s_csr_if.sink         csr_ch
);

   // Configuration registers
   logic [udc7s_pkg::CountWidth-1:0] max_value_ff;
   logic [udc7s_pkg::BeepWidth-1:0]  beep_ticks_ff;

   // Counter state
   logic [udc7s_pkg::CountWidth-1:0] count_ff, count_in;
   udc7s_pkg::bcd_type               bcd_ff, bcd_in;
   logic                             enabled_ff, enabled_in;
   logic [udc7s_pkg::BeepWidth-1:0]  beep_left_ff, beep_left_in;
   logic [udc7s_pkg::NumButtons-1:0] last_levels_ff;
   logic [udc7s_pkg::ScanWidth-1:0]  scan_pos_ff;

   // Result register
   logic                             out_valid_ff;
   logic [udc7s_pkg::SegWidth-1:0]   segments_ff, segments_in;
   logic [udc7s_pkg::NumDigits-1:0]  digit_sel_ff, digit_sel_in;
   logic                             green_ff;
   logic                             buzzer_ff, buzzer_in;
   logic [udc7s_pkg::CountWidth-1:0] count_out_ff;

   // Tick datapath
   logic [udc7s_pkg::NumButtons-1:0] levels;
   logic [udc7s_pkg::NumButtons-1:0] rise;
   logic [udc7s_pkg::CountWidth-1:0] limit;
   logic [udc7s_pkg::CountWidth-1:0] count_up;
   udc7s_pkg::bcd_type               bcd_up;
   logic                             up_ok, down_ok;
   logic [udc7s_pkg::BeepWidth-1:0]  beep_load;
   logic                             req_xfer;

   // Add one to a four-digit decimal value
   function automatic udc7s_pkg::bcd_type bcd_inc(input udc7s_pkg::bcd_type v);
      udc7s_pkg::bcd_type r;
      logic               carry;
      r     = v;
      carry = 1'b1;
      for (int i = 0; i < udc7s_pkg::NumDigits; i++) begin
         if (carry) begin
            if (v[i] == 4'd9) begin
               r[i] = 4'd0;
            end else begin
               r[i]  = v[i] + 4'd1;
               carry = 1'b0;
            end
         end
      end
      return r;
   endfunction

   // Take one from a four-digit decimal value
   function automatic udc7s_pkg::bcd_type bcd_dec(input udc7s_pkg::bcd_type v);
      udc7s_pkg::bcd_type r;
      logic               borrow;
      r      = v;
      borrow = 1'b1;
      for (int i = 0; i < udc7s_pkg::NumDigits; i++) begin
         if (borrow) begin
            if (v[i] == 4'd0) begin
               r[i] = 4'd9;
            end else begin
               r[i]   = v[i] - 4'd1;
               borrow = 1'b0;
            end
         end
      end
      return r;
   endfunction

   // Accept a tick while the result register is empty or being drained
   assign req_ch.ready = !out_valid_ff || rsp_ch.ready;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign levels = {req_ch.clear_pressed, req_ch.pause_pressed,
                    req_ch.down_pressed, req_ch.up_pressed};
   assign rise   = levels & ~last_levels_ff;
   assign limit  = (max_value_ff > udc7s_pkg::CountCeiling) ?
                   udc7s_pkg::CountCeiling : max_value_ff;

   // Up step, then down step on the updated count, then pause and clear
   always_comb begin
      up_ok    = rise[udc7s_pkg::BtnUp] && enabled_ff && (count_ff < limit);
      count_up = up_ok ? count_ff + 14'd1 : count_ff;
      bcd_up   = up_ok ? bcd_inc(bcd_ff) : bcd_ff;

      down_ok  = rise[udc7s_pkg::BtnDown] && enabled_ff && (count_up != '0);
      count_in = down_ok ? count_up - 14'd1 : count_up;
      bcd_in   = down_ok ? bcd_dec(bcd_up) : bcd_up;

      enabled_in = enabled_ff ^ rise[udc7s_pkg::BtnPause];
      if (rise[udc7s_pkg::BtnClear]) begin
         count_in   = '0;
         bcd_in     = '0;
         enabled_in = 1'b0;
      end
   end

   // Reload the beep countdown on a step, then count it down
   always_comb begin
      beep_load    = (up_ok || down_ok) ? beep_ticks_ff : beep_left_ff;
      buzzer_in    = (beep_load != '0);
      beep_left_in = buzzer_in ? beep_load - 16'd1 : beep_load;
   end

   // Drive the scanned digit
   always_comb begin
      segments_in              = udc7s_pkg::seg_of(bcd_in[scan_pos_ff]);
      digit_sel_in             = '1;
      digit_sel_in[scan_pos_ff] = 1'b0;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_value_ff  <= udc7s_pkg::MaxValueReset;
         beep_ticks_ff <= udc7s_pkg::BeepTicksReset;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.reg_index)
            udc7s_pkg::CSR_MAX_VALUE:
               max_value_ff <= csr_ch.wr_data[udc7s_pkg::CountWidth-1:0];
            udc7s_pkg::CSR_BEEP_TICKS:
               beep_ticks_ff <= csr_ch.wr_data;
            default: ;
         endcase
      end
   end

   // Advance the counter state on each tick transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         bcd_ff         <= '0;
         enabled_ff     <= 1'b0;
         beep_left_ff   <= '0;
         last_levels_ff <= '0;
         scan_pos_ff    <= '0;
      end else if (req_xfer) begin
         count_ff       <= count_in;
         bcd_ff         <= bcd_in;
         enabled_ff     <= enabled_in;
         beep_left_ff   <= beep_left_in;
         last_levels_ff <= levels;
         scan_pos_ff    <= scan_pos_ff + 2'd1;
      end
   end

   // Hold the result until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         segments_ff  <= segments_in;
         digit_sel_ff <= digit_sel_in;
         green_ff     <= enabled_in;
         buzzer_ff    <= buzzer_in;
         count_out_ff <= count_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.segments       = segments_ff;
   assign rsp_ch.digit_select_n = digit_sel_ff;
   assign rsp_ch.run_led        = green_ff;
   assign rsp_ch.red_led        = !green_ff;
   assign rsp_ch.buzzer         = buzzer_ff;
   assign rsp_ch.count_value    = count_out_ff;

endmodule

`default_nettype wire

@@ dv/up_down_counter_seven_segment_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the four-digit up/down counter with seven-segment scan.
// Depends on udc7s_pkg and the udc7s_req_if, udc7s_rsp_if and udc7s_csr_if interfaces.

module up_down_counter_seven_segment_test;

   // Button level masks, one bit per button
   localparam logic [udc7s_pkg::NumButtons-1:0] Released   = 4'b0000;
   localparam logic [udc7s_pkg::NumButtons-1:0] PressUp    = 4'b0001 << udc7s_pkg::BtnUp;
   localparam logic [udc7s_pkg::NumButtons-1:0] PressDown  = 4'b0001 << udc7s_pkg::BtnDown;
   localparam logic [udc7s_pkg::NumButtons-1:0] PressPause = 4'b0001 << udc7s_pkg::BtnPause;
   localparam logic [udc7s_pkg::NumButtons-1:0] PressClear = 4'b0001 << udc7s_pkg::BtnClear;

   // Register indexes with no register behind them
   localparam logic [udc7s_pkg::CsrIndexWidth-1:0] CsrSpareLow  = 2'd2;
   localparam logic [udc7s_pkg::CsrIndexWidth-1:0] CsrSpareHigh = 2'd3;

   localparam int unsigned MaxReported = 10;
   localparam int unsigned IdleLimit   = 2000;
   localparam int unsigned DrainCycles = 10;
   localparam int unsigned RampPresses = 40;

   localparam logic [udc7s_pkg::SegWidth-1:0] DigitPattern [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   typedef struct packed {
      logic [udc7s_pkg::SegWidth-1:0]   segments;
      logic [udc7s_pkg::NumDigits-1:0]  digit_select_n;
      logic                             run_led;
      logic                             red_led;
      logic                             buzzer;
      logic [udc7s_pkg::CountWidth-1:0] count_value;
   } display_update_type;

   logic clock;
   logic reset;

   udc7s_req_if req_ch ();
   udc7s_rsp_if rsp_ch ();
   udc7s_csr_if csr_ch ();

   up_down_counter_seven_segment u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predicted counter state and register copies
   logic [udc7s_pkg::CountWidth-1:0]  shown_count    = '0;
   logic                              counting_on    = 1'b0;
   logic [udc7s_pkg::BeepWidth-1:0]   beep_remaining = '0;
   logic [udc7s_pkg::NumButtons-1:0]  prev_levels    = '0;
   logic [udc7s_pkg::ScanWidth-1:0]   scan_digit     = '0;
   logic [udc7s_pkg::CountWidth-1:0]  limit_setting  = udc7s_pkg::MaxValueReset;
   logic [udc7s_pkg::BeepWidth-1:0]   beep_setting   = udc7s_pkg::BeepTicksReset;

   logic [udc7s_pkg::NumButtons-1:0]  pending_levels [$];
   display_update_type                expected_updates [$];

   logic                              quiet_phase;
   int unsigned                       tick_gap;
   int unsigned                       stall_left;
   int unsigned                       idle_cycles;
   int unsigned                       failures;
   int unsigned                       ticks_checked;
   int unsigned                       buzzer_ticks;
   int unsigned                       settings_applied;
   int unsigned                       peak_count;
   logic [udc7s_pkg::NumButtons-1:0]  next_levels;
   logic [udc7s_pkg::NumButtons-1:0]  tick_levels;
   display_update_type                seen_update;

   always #1 clock = ~clock;

   // Advance the predicted state by one scan tick and return the display update
   function automatic display_update_type predict_tick(
         input logic [udc7s_pkg::NumButtons-1:0] levels);
      logic [udc7s_pkg::NumButtons-1:0] rise;
      logic [udc7s_pkg::CountWidth-1:0] limit;
      int unsigned                      divisor;
      display_update_type               upd;
      rise  = levels & ~prev_levels;
      limit = (limit_setting > udc7s_pkg::CountCeiling) ?
              udc7s_pkg::CountCeiling : limit_setting;
      if (rise[udc7s_pkg::BtnUp] && counting_on && shown_count < limit) begin
         beep_remaining = beep_setting;
         shown_count    = shown_count + 1'b1;
      end
      if (rise[udc7s_pkg::BtnDown] && counting_on && shown_count > 0) begin
         beep_remaining = beep_setting;
         shown_count    = shown_count - 1'b1;
      end
      if (rise[udc7s_pkg::BtnPause])
         counting_on = ~counting_on;
      if (rise[udc7s_pkg::BtnClear]) begin
         shown_count = '0;
         counting_on = 1'b0;
      end
      prev_levels = levels;
      upd.buzzer = (beep_remaining != 0);
      if (upd.buzzer)
         beep_remaining = beep_remaining - 1'b1;
      case (scan_digit)
         2'd0:    divisor = 1;
         2'd1:    divisor = 10;
         2'd2:    divisor = 100;
         default: divisor = 1000;
      endcase
      upd.segments       = DigitPattern[(shown_count / divisor) % 10];
      upd.digit_select_n = ~(4'b0001 << scan_digit);
      upd.run_led        = counting_on;
      upd.red_led        = ~counting_on;
      upd.count_value    = shown_count;
      scan_digit         = scan_digit + 1'b1;
      return upd;
   endfunction

   // Mostly short gaps, a few long ones, none in a quiet phase
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (quiet_phase || roll < 50)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic note_failure(input string what, input display_update_type want,
                               input display_update_type got);
      failures++;
      if (failures <= MaxReported) begin
         $display("%s: want seg=%h sel=%b run=%b red=%b buz=%b cnt=%0d",
                  what, want.segments, want.digit_select_n, want.run_led, want.red_led,
                  want.buzzer, want.count_value);
         $display("%s: got  seg=%h sel=%b run=%b red=%b buz=%b cnt=%0d",
                  what, got.segments, got.digit_select_n, got.run_led, got.red_led,
                  got.buzzer, got.count_value);
      end
   endtask

   // Queue one press and release of the given buttons
   task automatic queue_press(input logic [udc7s_pkg::NumButtons-1:0] mask);
      pending_levels.push_back(mask);
      pending_levels.push_back(Released);
   endtask

   // Queue press/hold/release sequences with weighted buttons, the rest noise
   task automatic queue_random_ticks(input int unsigned count, input int unsigned up_w,
                                     input int unsigned down_w, input int unsigned pause_w,
                                     input int unsigned clear_w);
      int unsigned                      added;
      int unsigned                      roll;
      logic [udc7s_pkg::NumButtons-1:0] mask;
      logic [udc7s_pkg::NumButtons-1:0] noise_mask;
      noise_mask = {clear_w != 0, pause_w != 0, down_w != 0, up_w != 0};
      added = 0;
      while (added < count) begin
         roll = $urandom_range(99);
         if (roll < up_w + down_w + pause_w + clear_w) begin
            if (roll < up_w)
               mask = PressUp;
            else if (roll < up_w + down_w)
               mask = PressDown;
            else if (roll < up_w + down_w + pause_w)
               mask = PressPause;
            else
               mask = PressClear;
            repeat ($urandom_range(1, 3)) begin
               pending_levels.push_back(mask);
               added++;
            end
            repeat ($urandom_range(1, 2)) begin
               pending_levels.push_back(Released);
               added++;
            end
         end else begin
            pending_levels.push_back(4'($urandom) & noise_mask);
            added++;
         end
      end
   endtask

   // Hold until every queued tick has been transferred and answered
   task automatic wait_idle();
      do begin
         while (pending_levels.size() != 0 || expected_updates.size() != 0 || req_ch.valid)
            @(negedge clock);
         repeat (3) @(negedge clock);
      end while (pending_levels.size() != 0 || expected_updates.size() != 0 || req_ch.valid);
   endtask

   // One register write, applied to the predictor at its transfer
   task automatic write_register(input logic [udc7s_pkg::CsrIndexWidth-1:0] index,
                                 input logic [udc7s_pkg::CsrDataWidth-1:0] data);
      @(posedge clock);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= index;
      csr_ch.wr_data   <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (index)
         udc7s_pkg::CSR_MAX_VALUE:  limit_setting = data[udc7s_pkg::CountWidth-1:0];
         udc7s_pkg::CSR_BEEP_TICKS: beep_setting  = data;
         default: ;
      endcase
      settings_applied++;
   endtask

   task automatic set_registers(input logic [udc7s_pkg::CsrDataWidth-1:0] max_value,
                                input logic [udc7s_pkg::CsrDataWidth-1:0] beep_ticks);
      wait_idle();
      write_register(udc7s_pkg::CSR_MAX_VALUE, max_value);
      write_register(udc7s_pkg::CSR_BEEP_TICKS, beep_ticks);
      @(negedge clock);
   endtask

   // Tick driver: one transfer per accepted item, random gaps in between
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         tick_gap = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (tick_gap != 0) begin
            tick_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_levels.size() != 0) begin
            next_levels = pending_levels.pop_front();
            req_ch.up_pressed    <= next_levels[udc7s_pkg::BtnUp];
            req_ch.down_pressed  <= next_levels[udc7s_pkg::BtnDown];
            req_ch.pause_pressed <= next_levels[udc7s_pkg::BtnPause];
            req_ch.clear_pressed <= next_levels[udc7s_pkg::BtnClear];
            req_ch.valid         <= 1'b1;
            tick_gap = pick_gap();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result monitor: predict on each tick transfer, check each result transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            tick_levels[udc7s_pkg::BtnUp]    = req_ch.up_pressed;
            tick_levels[udc7s_pkg::BtnDown]  = req_ch.down_pressed;
            tick_levels[udc7s_pkg::BtnPause] = req_ch.pause_pressed;
            tick_levels[udc7s_pkg::BtnClear] = req_ch.clear_pressed;
            expected_updates.push_back(predict_tick(tick_levels));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_update.segments       = rsp_ch.segments;
            seen_update.digit_select_n = rsp_ch.digit_select_n;
            seen_update.run_led        = rsp_ch.run_led;
            seen_update.red_led        = rsp_ch.red_led;
            seen_update.buzzer         = rsp_ch.buzzer;
            seen_update.count_value    = rsp_ch.count_value;
            ticks_checked++;
            if (seen_update.buzzer === 1'b1)
               buzzer_ticks++;
            if (32'(seen_update.count_value) > peak_count)
               peak_count = 32'(seen_update.count_value);
            if (expected_updates.size() == 0)
               note_failure("unexpected result", '0, seen_update);
            else if (seen_update !== expected_updates[0]) begin
               note_failure("result mismatch", expected_updates[0], seen_update);
               void'(expected_updates.pop_front());
            end else
               void'(expected_updates.pop_front());
         end
         // Drop ready for random stalls
         if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (quiet_phase || $urandom_range(9) < 7) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            stall_left = pick_gap();
            rsp_ch.ready <= 1'b0;
         end
      end
   end

   // Watchdog on cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("Timeout after %0d cycles with no transfer", IdleLimit);
            $display("** up_down_counter_seven_segment: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      quiet_phase          = 1'b0;
      failures             = 0;
      ticks_checked        = 0;
      buzzer_ticks         = 0;
      settings_applied     = 0;
      peak_count           = 0;
      idle_cycles          = 0;
      req_ch.valid         = 1'b0;
      req_ch.up_pressed    = 1'b0;
      req_ch.down_pressed  = 1'b0;
      req_ch.pause_pressed = 1'b0;
      req_ch.clear_pressed = 1'b0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.reg_index     = udc7s_pkg::CSR_MAX_VALUE;
      csr_ch.wr_data       = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: presses while paused, enable, steps, chords, clear
      pending_levels.push_back(Released);
      queue_press(PressUp);
      queue_press(PressDown);
      queue_press(PressPause);
      pending_levels.push_back(PressUp);
      pending_levels.push_back(PressUp);
      pending_levels.push_back(Released);
      queue_press(PressUp | PressDown);
      queue_press(PressDown);
      queue_press(PressDown);
      queue_press(PressPause | PressUp);
      queue_press(PressUp);
      queue_press(PressUp | PressDown | PressPause | PressClear);
      queue_press(PressPause);
      queue_press(PressUp);
      queue_press(PressClear);
      queue_random_ticks(100, 40, 25, 20, 5);

      // Tiny limit with zero beep time
      set_registers(16'd3, 16'd0);
      queue_random_ticks(100, 40, 20, 20, 10);

      // Short beep, moderate limit
      set_registers(16'd40, 16'd3);
      queue_random_ticks(100, 50, 20, 15, 5);

      // Lower the limit under the count, upper data bits set
      set_registers(16'hC005, 16'd3);
      queue_random_ticks(80, 30, 40, 20, 0);

      // Limit above the ceiling and longest beep; spare indexes are ignored
      wait_idle();
      write_register(CsrSpareLow, 16'h0001);
      write_register(CsrSpareHigh, 16'hFFFF);
      set_registers(16'hFFFF, 16'hFFFF);

      // Ramp the count upwards without gaps or stalls
      quiet_phase = 1'b1;
      pending_levels.push_back(Released);
      queue_press(PressClear);
      queue_press(PressPause);
      repeat (RampPresses) queue_press(PressUp);
      wait_idle();
      quiet_phase = 1'b0;
      queue_random_ticks(100, 45, 40, 10, 0);

      // Limit exactly at the ceiling
      set_registers(16'd9999, 16'd2);
      queue_random_ticks(80, 45, 40, 10, 0);

      // Zero limit: up never steps, down still does
      set_registers(16'd0, 16'd1);
      queue_random_ticks(60, 40, 30, 20, 10);

      // Back to the reset beep time with a small limit
      wait_idle();
      write_register(CsrSpareHigh, 16'h0000);
      set_registers(16'd12, udc7s_pkg::BeepTicksReset);
      queue_random_ticks(80, 40, 25, 20, 15);

      wait_idle();
      repeat (DrainCycles) @(posedge clock);
      if (expected_updates.size() != 0) begin
         failures++;
         $display("%0d expected results never arrived", expected_updates.size());
      end
      $display("Checked %0d scan ticks across %0d register writes, with a gapless ramp.",
               ticks_checked, settings_applied);
      $display("Count peaked at %0d; buzzer on for %0d ticks; %0d failures.",
               peak_count, buzzer_ticks, failures);
      if (failures == 0)
         $display("** up_down_counter_seven_segment: PASSED **");
      else
         $display("** up_down_counter_seven_segment: FAILED **");
      $finish;
   end

endmodule
